// ===== rtl/ofrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ofrq_pkg
// Shared types, constants and ring helpers for the oldest-first ready queue.
// ----------------------------------------------------------------------------
package ofrq_pkg;

   // Ring geometry: SLOTS positions, SLOTS-1 usable entries
   localparam int SLOTS = 8;
   localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS - 1);
   localparam logic [PTR_W-1:0] CNT_FULL = PTR_W'(SLOTS - 1);

   // Request modes
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_POP = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [5:0]  entry_index;
      logic [15:0] age_clock;
      logic [15:0] age_seq;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] popped_index;
      logic [2:0] count;
   } rsp_type;

   // One stored ring entry
   typedef struct packed {
      logic [5:0]  index;
      logic [15:0] clock;
      logic [15:0] seq;
   } slot_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_FINISH
   } state_type;

   // Advance a ring position with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   // Entries between head and tail, modulo SLOTS
   function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail);
      logic [PTR_W:0] sum;
      sum = {1'b0, tail} + (PTR_W+1)'(SLOTS) - {1'b0, head};
      if (tail >= head) begin
         sum = {1'b0, tail} - {1'b0, head};
      end
      return sum[PTR_W-1:0];
   endfunction

   // Report the count in the three-bit result field
   function automatic logic [2:0] count_field(input logic [PTR_W-1:0] c);
      logic [PTR_W+2:0] wide;
      wide = {3'b000, c};
      return wide[2:0];
   endfunction

   // Strictly older: smaller stamp, then smaller sequence number
   function automatic logic is_older(input slot_type a, input slot_type b);
      return (a.clock < b.clock) || ((a.clock == b.clock) && (a.seq < b.seq));
   endfunction

endpackage

// ===== rtl/oldest_first_ready_queue.sv =====
// ----------------------------------------------------------------------------
// oldest_first_ready_queue
// Ring of age-tagged station indices; adds go to the tail, pops return the
// oldest entry and refill its slot from the head.
// ----------------------------------------------------------------------------
//
//   channel   ports                        payload
//   request   req_valid / req_stall        req_data (ofrq_pkg::req_type)
//   result    rsp_valid / rsp_stall        rsp_data (ofrq_pkg::rsp_type)
//
// An add goes through accept with the memory write, then the result load.
// A successful pop goes through the head read at accept, a scan with one memory
// read per entry, the write-back of the head entry, then the result load.
// A rejected add or pop goes from accept straight to the result load. One request is in work at a time.
// Reset (synchronous) clears the pointers and the result flag; entry storage
// is left as is. A new request is taken while a result waits on rsp_stall.
module oldest_first_ready_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ofrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ofrq_pkg::rsp_type rsp_data
);

   localparam int PTR_W = ofrq_pkg::PTR_W;

   // Entry storage
   ofrq_pkg::slot_type mem [ofrq_pkg::SLOTS];

   ofrq_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [PTR_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [PTR_W-1:0]    best_pos_ff, best_pos_in;
   logic                first_ff, first_in;
   ofrq_pkg::slot_type  best_ff, best_in;
   ofrq_pkg::slot_type  head_copy_ff, head_copy_in;
   ofrq_pkg::slot_type  rd_data_ff;
   logic [1:0]          res_status_ff, res_status_in;
   logic [5:0]          res_popped_ff, res_popped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ofrq_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                mem_we;
   logic [PTR_W-1:0]    mem_waddr;
   ofrq_pkg::slot_type  mem_wdata;
   logic                mem_re;
   logic [PTR_W-1:0]    mem_raddr;
   logic                rsp_load;
   logic                out_free;
   logic [PTR_W-1:0]    cnt;
   logic [PTR_W-1:0]    rd_next;
   logic                req_accept;

   assign cnt        = ofrq_pkg::ring_count(head_ff, tail_ff);
   assign rd_next    = ofrq_pkg::ring_next(rd_pos_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ofrq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == ofrq_pkg::MODE_POP && cnt != '0) begin
                  state_in = ofrq_pkg::S_SCAN;
               end else begin
                  state_in = ofrq_pkg::S_FINISH;
               end
            end
         end
         ofrq_pkg::S_SCAN: begin
            if (rd_next == tail_ff) begin
               state_in = ofrq_pkg::S_WRITE;
            end
         end
         ofrq_pkg::S_WRITE: begin
            state_in = ofrq_pkg::S_FINISH;
         end
         ofrq_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = ofrq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ofrq_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_stall     = 1'b1;
      mem_we        = 1'b0;
      mem_waddr     = tail_ff;
      mem_wdata     = head_copy_ff;
      mem_re        = 1'b0;
      mem_raddr     = head_ff;
      rsp_load      = 1'b0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rd_pos_in     = rd_pos_ff;
      best_pos_in   = best_pos_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      head_copy_in  = head_copy_ff;
      res_status_in = res_status_ff;
      res_popped_in = res_popped_ff;
      unique case (state_ff)
         ofrq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               res_popped_in = '0;
               res_status_in = ofrq_pkg::ST_DONE;
               if (req_data.mode == ofrq_pkg::MODE_ADD) begin
                  // Write at tail unless full
                  if (cnt == ofrq_pkg::CNT_FULL) begin
                     res_status_in = ofrq_pkg::ST_FULL;
                  end else begin
                     mem_we          = 1'b1;
                     mem_waddr       = tail_ff;
                     mem_wdata.index = req_data.entry_index;
                     mem_wdata.clock = req_data.age_clock;
                     mem_wdata.seq   = req_data.age_seq;
                     tail_in         = ofrq_pkg::ring_next(tail_ff);
                  end
               end else begin
                  // Start the scan at head unless empty
                  if (cnt == '0) begin
                     res_status_in = ofrq_pkg::ST_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = head_ff;
                     rd_pos_in = head_ff;
                     first_in  = 1'b1;
                  end
               end
            end
         end
         ofrq_pkg::S_SCAN: begin
            // Keep the strictly older candidate; ties stay nearer the head
            if (first_ff || ofrq_pkg::is_older(rd_data_ff, best_ff)) begin
               best_in     = rd_data_ff;
               best_pos_in = rd_pos_ff;
            end
            if (first_ff) begin
               head_copy_in = rd_data_ff;
            end
            first_in = 1'b0;
            // Fetch the next ring position until the tail
            if (rd_next != tail_ff) begin
               mem_re    = 1'b1;
               mem_raddr = rd_next;
               rd_pos_in = rd_next;
            end
         end
         ofrq_pkg::S_WRITE: begin
            // Move the head entry into the freed slot and drop the head
            mem_we        = 1'b1;
            mem_waddr     = best_pos_ff;
            mem_wdata     = head_copy_ff;
            head_in       = ofrq_pkg::ring_next(head_ff);
            res_status_in = ofrq_pkg::ST_DONE;
            res_popped_in = best_ff.index;
         end
         ofrq_pkg::S_FINISH: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = res_status_ff;
         rsp_data_in.popped_index = res_popped_ff;
         rsp_data_in.count        = ofrq_pkg::count_field(cnt);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ofrq_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_pos_ff     <= rd_pos_in;
      best_pos_ff   <= best_pos_in;
      best_ff       <= best_in;
      head_copy_ff  <= head_copy_in;
      res_status_ff <= res_status_in;
      res_popped_ff <= res_popped_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Full ring rejects an add without moving the tail
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.mode == ofrq_pkg::MODE_ADD && cnt == ofrq_pkg::CNT_FULL)
      |=> ($stable(tail_ff) && res_status_ff == ofrq_pkg::ST_FULL))
      else $error("add on full ring changed the tail");

   // Empty ring rejects a pop and goes straight to the result
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.mode == ofrq_pkg::MODE_POP && cnt == '0)
      |=> (res_status_ff == ofrq_pkg::ST_EMPTY && state_ff == ofrq_pkg::S_FINISH))
      else $error("pop on empty ring not rejected");

   // Selected slot lies inside the occupied part of the ring
   a_best_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ofrq_pkg::S_WRITE) |-> (ofrq_pkg::ring_count(head_ff, best_pos_ff) < cnt))
      else $error("selected slot outside the ring");

   // Head moves only out of the write-back cycle
   a_head_move: assert property (@(posedge clock) disable iff (reset)
      !$stable(head_ff) |-> ($past(state_ff) == ofrq_pkg::S_WRITE))
      else $error("head moved outside write-back");

endmodule
